[src/lfgr_pkg.sv]
// Package: shared widths, direction and command codes for the fade ramp.
`default_nettype none
package lfgr_pkg;

    localparam int unsigned FIELD_TIME_W = 24;   // delta_us and cfg_wr_data (fade length) port width
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned DIR_W        = 2;
    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned VOL_W        = FRAC_BITS + 1;

    typedef logic [FIELD_TIME_W-1:0] time_field_t;
    typedef logic [CMD_W-1:0]        cmd_t;
    typedef logic [DIR_W-1:0]        dir_t;
    typedef logic [VOL_W-1:0]        vol_t;

    localparam cmd_t CMD_KEEP = 2'd0;
    localparam cmd_t CMD_IN   = 2'd1;
    localparam cmd_t CMD_OUT  = 2'd2;

    localparam dir_t DIR_HOLD = 2'd0;
    localparam dir_t DIR_IN   = 2'd1;
    localparam dir_t DIR_OUT  = 2'd2;

    localparam vol_t VOL_ONE  = vol_t'(1) << FRAC_BITS;

endpackage
`default_nettype wire

[src/lfgr_in_if.sv]
// Interface: input update channel (delta time and fade command).
`default_nettype none
interface lfgr_in_if;
    import lfgr_pkg::*;

    logic        valid;
    logic        ready;
    time_field_t delta_us;
    cmd_t        fade_command;

    modport source (output valid, output delta_us, output fade_command, input ready);
    modport sink   (input valid, input delta_us, input fade_command, output ready);
endinterface
`default_nettype wire

[src/lfgr_out_if.sv]
// Interface: result channel (volume, direction, fade-out flag).
`default_nettype none
interface lfgr_out_if;
    import lfgr_pkg::*;

    logic valid;
    logic ready;
    vol_t volume;
    dir_t direction_now;
    logic faded_out;

    modport source (output valid, output volume, output direction_now, output faded_out,
                    input ready);
    modport sink   (input valid, input volume, input direction_now, input faded_out,
                    output ready);
endinterface
`default_nettype wire

[src/linear_fade_gain_ramp_unit.sv]
// Top level: linear volume fade ramp with serial volume divider.
`default_nettype none
// Linear fade gain ramp. Each input beat carries the microseconds elapsed since
// the previous update and a fade command (keep, start fade-in, start fade-out;
// code 3 is ignored). The command takes effect first, then the fade position
// moves by the delta in the current direction and is clamped to [0, length].
// The result beat gives volume = (position << 16) / length in unsigned Q1.16
// (65536 is unity), the direction after the update, and a fade-out flag that is
// set whenever a non-bypass update leaves a fade-out at zero. A finished fade-in
// returns the direction to hold. A length of zero bypasses the ramp: volume is
// unity, the position is frozen, but commands still change the direction.
// Timing: one update at a time. The position update happens in the accept
// cycle; the volume comes from a restoring divider that retires one quotient
// bit per cycle. An update passes through loading the divider, the quotient
// bits, capturing the quotient and moving it into the output register, where
// the result beat shows up; the next beat can be taken once that move is done.
// With a zero length the divider is skipped. While the output register still
// holds an unaccepted beat, a finished update waits, and every such stall
// cycle adds to the time before the input is ready again. A finished result
// sits in an output register while the next beat is taken. The length
// register is written through cfg_wr_en / cfg_wr_data and should only change
// while the unit is idle. TIME_BITS sets the width of the position
// arithmetic; delta and length are taken modulo 2^TIME_BITS.
module linear_fade_gain_ramp_unit #(
    parameter int unsigned TIME_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire lfgr_pkg::time_field_t cfg_wr_data,
    lfgr_in_if.sink                    in_ch,
    lfgr_out_if.source                 out_ch
);
    import lfgr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef logic [TIME_BITS-1:0] pos_t;
    typedef logic [TIME_BITS:0]   pos_ext_t;

    logic [1:0]  state_reg, state_next;
    time_field_t len_reg;
    pos_t        pos_reg, pos_next;
    dir_t        dir_reg, dir_next;

    // pending result of the update in flight
    dir_t        res_dir_reg;
    logic        res_flag_reg;
    vol_t        res_vol_reg;

    // output stage
    logic        out_valid_reg, out_valid_next;
    vol_t        out_vol_reg;
    dir_t        out_dir_reg;
    logic        out_flag_reg;

    logic        accept;
    logic        load_out;
    pos_t        len;
    pos_t        delta;
    logic        bypass;
    dir_t        dir_cmd;
    pos_ext_t    moved;
    pos_ext_t    clamped;
    pos_t        new_pos;
    dir_t        dir_final;
    logic        flag;
    logic        div_start;
    logic        div_done;
    vol_t        div_quo;

    assign len    = TIME_BITS'(len_reg);
    assign delta  = TIME_BITS'(in_ch.delta_us);
    assign bypass = (len == '0);
    assign accept = in_ch.valid && (state_reg == ST_IDLE);
    assign in_ch.ready = (state_reg == ST_IDLE);

    // command first, then move and clamp
    always_comb
    begin
        case (in_ch.fade_command)
            CMD_IN:  dir_cmd = DIR_IN;
            CMD_OUT: dir_cmd = DIR_OUT;
            default: dir_cmd = dir_reg;
        endcase

        case (dir_cmd)
            DIR_IN:  moved = {1'b0, pos_reg} + {1'b0, delta};
            DIR_OUT: moved = (pos_reg > delta) ? {1'b0, pos_reg - delta} : '0;
            default: moved = {1'b0, pos_reg};
        endcase

        clamped = (moved > {1'b0, len}) ? {1'b0, len} : moved;
        new_pos = clamped[TIME_BITS-1:0];

        if (bypass)
        begin
            dir_final = dir_cmd;
            flag      = 1'b0;
        end
        else
        begin
            flag = (dir_cmd == DIR_OUT) && (new_pos == '0);
            if ((dir_cmd == DIR_IN) && (new_pos >= len))
                dir_final = DIR_HOLD;
            else
                dir_final = dir_cmd;
        end
    end

    assign div_start = accept && !bypass;

    lfgr_div #(
        .W (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (new_pos),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dir_next   = dir_final;
                    pos_next   = bypass ? pos_reg : new_pos;
                    state_next = bypass ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            dir_reg       <= DIR_HOLD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_dir_reg  <= dir_final;
            res_flag_reg <= flag;
            res_vol_reg  <= VOL_ONE;   // zero length: unity gain
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            res_vol_reg <= div_quo;
        end

        if (load_out)
        begin
            out_vol_reg  <= res_vol_reg;
            out_dir_reg  <= res_dir_reg;
            out_flag_reg <= res_flag_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.volume        = out_vol_reg;
    assign out_ch.direction_now = out_dir_reg;
    assign out_ch.faded_out     = out_flag_reg;

endmodule
`default_nettype wire

[src/lfgr_div.sv]
// Serial restoring divider: (pos << 16) / len, one quotient bit per cycle, pos <= len.
`default_nettype none
module lfgr_div #(
    parameter int unsigned W = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [W-1:0]         dividend,
    input  wire logic [W-1:0]         divisor,
    output      logic                 done,
    output      lfgr_pkg::vol_t       quotient
);
    import lfgr_pkg::*;

    localparam int unsigned STEPS = VOL_W;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     div_reg;
    vol_t             quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic             ge;
    logic [W:0]       diff;
    logic [W:0]       rem_after;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, div_reg};
        diff      = rem_reg - {1'b0, div_reg};
        rem_after = ge ? diff : rem_reg;

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = {1'b0, dividend};
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor after the subtract, so the shift fits
            quo_next = {quo_reg[VOL_W-2:0], ge};
            rem_next = {rem_after[W-1:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire
